@@ design/bpa_pkg.sv @@
// Shared types and codes for the bitmap page allocator.
// Beat payloads, status and strategy codes, and the scan-unit control structs.
// No dependencies.
package bpa_pkg;

    // Default map size
    localparam int DEFAULT_PAGES = 16;

    // Operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Fit strategies
    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_NEXT  = 2'd1;
    localparam logic [1:0] FIT_BEST  = 2'd2;
    localparam logic [1:0] FIT_WORST = 2'd3;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_INVALID = 2'd2
    } status_t;

    // Request beat
    typedef struct packed {
        logic       operation;
        logic [4:0] page_count;
        logic [3:0] start_page;
    } req_t;

    // Response beat
    typedef struct packed {
        logic [3:0] granted_page;
        status_t    status;
    } rsp_t;

    // Sequencer to scan unit
    typedef struct packed {
        logic load;
        logic hole_mode;
        logic want_large;
    } scan_ctl_t;

    // Scan unit to sequencer
    typedef struct packed {
        logic running;
        logic found;
    } scan_stat_t;

endpackage

@@ design/bpa_scan.sv @@
// Shared scan unit: walks the occupancy map one page per cycle.
// Run-length tracking for first and next fit, and hole compare for best/worst fit.
// Depends on bpa_pkg.
module bpa_scan import bpa_pkg::*;
#(
    parameter int PAGES = DEFAULT_PAGES
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  scan_ctl_t                    ctl,
    input  logic [$clog2(PAGES+1)-1:0]   from,
    input  logic [4:0]                   count,
    input  logic [PAGES-1:0]             map,
    output scan_stat_t                   stat,
    output logic [$clog2(PAGES)-1:0]     pick
);

    localparam int AW = $clog2(PAGES);
    localparam int IW = $clog2(PAGES + 1);
    localparam int CW = (IW > 5) ? IW : 5;

    logic          run_reg,   run_next;
    logic          hole_reg,  hole_next;
    logic          large_reg, large_next;
    logic          found_reg, found_next;
    logic [IW-1:0] idx_reg,   idx_next;
    logic [IW-1:0] len_reg,   len_next;
    logic [AW-1:0] begin_reg, begin_next;
    logic [AW-1:0] pick_reg,  pick_next;
    logic [IW-1:0] plen_reg,  plen_next;

    logic          at_end;
    logic          busy_bit;
    logic [IW-1:0] len_inc;
    logic [AW-1:0] begin_cur;
    logic [CW-1:0] cnt_x;
    logic          better;

    // Current page lookup; the slot past the last page reads busy
    always_comb
    begin
        at_end    = (idx_reg >= IW'(PAGES));
        busy_bit  = at_end ? 1'b1 : map[idx_reg[AW-1:0]];
        len_inc   = len_reg + IW'(1);
        begin_cur = (len_reg == '0) ? idx_reg[AW-1:0] : begin_reg;
        cnt_x     = CW'(count);
        better    = !found_reg || (large_reg ? (len_reg > plen_reg) : (len_reg < plen_reg));
    end

    // One scan step per cycle
    always_comb
    begin
        run_next   = run_reg;
        hole_next  = hole_reg;
        large_next = large_reg;
        found_next = found_reg;
        idx_next   = idx_reg;
        len_next   = len_reg;
        begin_next = begin_reg;
        pick_next  = pick_reg;
        plen_next  = plen_reg;
        if (ctl.load)
        begin
            run_next   = 1'b1;
            hole_next  = ctl.hole_mode;
            large_next = ctl.want_large;
            found_next = 1'b0;
            idx_next   = from;
            len_next   = '0;
            plen_next  = '0;
        end
        else if (run_reg)
        begin
            idx_next = idx_reg + IW'(1);
            if (!hole_reg)
            begin
                // first fit from the load position
                if (at_end)
                begin
                    run_next = 1'b0;
                end
                else if (busy_bit)
                begin
                    len_next = '0;
                end
                else
                begin
                    begin_next = begin_cur;
                    len_next   = len_inc;
                    if (CW'(len_inc) == cnt_x)
                    begin
                        found_next = 1'b1;
                        pick_next  = begin_cur;
                        run_next   = 1'b0;
                    end
                end
            end
            else
            begin
                // hole compare at the end of each free run
                if (!busy_bit)
                begin
                    begin_next = begin_cur;
                    len_next   = len_inc;
                end
                else
                begin
                    if ((CW'(len_reg) >= cnt_x) && better)
                    begin
                        found_next = 1'b1;
                        pick_next  = begin_reg;
                        plen_next  = len_reg;
                    end
                    len_next = '0;
                    if (at_end)
                    begin
                        run_next = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            hole_reg  <= 1'b0;
            large_reg <= 1'b0;
            found_reg <= 1'b0;
            idx_reg   <= '0;
            len_reg   <= '0;
        end
        else
        begin
            run_reg   <= run_next;
            hole_reg  <= hole_next;
            large_reg <= large_next;
            found_reg <= found_next;
            idx_reg   <= idx_next;
            len_reg   <= len_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        begin_reg <= begin_next;
        pick_reg  <= pick_next;
        plen_reg  <= plen_next;
    end

    assign stat.running = run_reg;
    assign stat.found   = found_reg;
    assign pick         = pick_reg;

endmodule

@@ design/bitmap_page_allocator_fit.sv @@
// Contiguous page allocator over a PAGES-bit occupancy map.
// Request channel req (valid/ready) carries operation, page_count, start_page;
// response channel rsp (valid/ready) returns granted_page and status, one
// beat per request. The one config register, fit_strategy, is written by
// cfg_we/cfg_wdata and selects first, next, best or worst fit; the user
// must write it only while the block is idle; the block does not enforce it.
// One request is in flight at a time: req_ready is high only while idle.
// Free and invalid requests go to the S_DONE state, which registers the
// response once the output slot is free; the next request waits for idle.
// An allocate walks the map through one shared scan unit, one page per cycle;
// next fit may add a wrap pass from page 0. The scan unit limits the rate.
// The response sits in an output register. While the receiver stalls a new
// request may still be taken; its result and map update wait in the
// sequencer until the pending response beat goes out.
// Reset (rst_n, async, active low) frees all pages, clears the next-fit
// position and selects first fit.
// Depends on bpa_pkg and bpa_scan.
module bitmap_page_allocator_fit import bpa_pkg::*;
#(
    parameter int PAGES = DEFAULT_PAGES
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  req_t       req,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output rsp_t       rsp,
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata
);

    localparam int AW = $clog2(PAGES);
    localparam int IW = $clog2(PAGES + 1);
    localparam int XW = (IW > 5) ? IW : 5;
    localparam int SW = XW + 1;
    localparam int GW = (AW > 4) ? AW : 4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        UPD_NONE,
        UPD_SET,
        UPD_CLR
    } upd_t;

    state_t           state_reg,  state_next;
    upd_t             upd_reg,    upd_next;
    logic             pass2_reg,  pass2_next;
    logic             nfupd_reg,  nfupd_next;
    logic [1:0]       strat_reg,  strat_next;
    logic [PAGES-1:0] map_reg,    map_next;
    logic [4:0]       nf_reg,     nf_next;
    logic             rvalid_reg, rvalid_next;
    rsp_t             rsp_reg,    rsp_next;
    status_t          stat_reg,   stat_next;
    logic [4:0]       cnt_reg,    cnt_next;
    logic [SW-1:0]    lo_reg,     lo_next;

    scan_ctl_t        scan_ctl;
    scan_stat_t       scan_stat;
    logic [IW-1:0]    scan_from;
    logic [AW-1:0]    scan_pick;

    logic             accept;
    logic             slot_free;
    logic [SW-1:0]    hi;
    logic [PAGES-1:0] mask;
    logic [SW-1:0]    req_end;
    logic             bad_alloc;
    logic             bad_free;
    logic [XW-1:0]    nf_x;
    logic [5:0]       nf_sum;
    logic [GW-1:0]    lo_g;

    assign accept    = req_valid && req_ready;
    assign slot_free = !rvalid_reg || rsp_ready;

    // Request checks
    always_comb
    begin
        req_end   = SW'(req.start_page) + SW'(req.page_count);
        bad_alloc = (req.page_count == '0) || (SW'(req.page_count) > SW'(PAGES));
        bad_free  = (req.page_count == '0) || (SW'(req.start_page) >= SW'(PAGES))
                    || (req_end > SW'(PAGES));
    end

    // Run mask over [lo, lo + count)
    always_comb
    begin
        hi = lo_reg + SW'(cnt_reg);
        for (int p = 0; p < PAGES; p++)
        begin
            mask[p] = (SW'(p) >= lo_reg) && (SW'(p) < hi);
        end
    end

    assign nf_x   = XW'(nf_reg);
    assign nf_sum = 6'(lo_reg[4:0]) + 6'(cnt_reg);
    assign lo_g   = GW'(lo_reg);

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        upd_next    = upd_reg;
        pass2_next  = pass2_reg;
        nfupd_next  = nfupd_reg;
        strat_next  = cfg_we ? cfg_wdata : strat_reg;
        map_next    = map_reg;
        nf_next     = nf_reg;
        rvalid_next = rvalid_reg && !rsp_ready;
        rsp_next    = rsp_reg;
        stat_next   = stat_reg;
        cnt_next    = cnt_reg;
        lo_next     = lo_reg;
        scan_ctl    = '0;
        scan_from   = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cnt_next   = req.page_count;
                    lo_next    = SW'(req.start_page);
                    upd_next   = UPD_NONE;
                    nfupd_next = 1'b0;
                    pass2_next = 1'b0;
                    if (req.operation == OP_FREE)
                    begin
                        stat_next  = bad_free ? ST_INVALID : ST_DONE;
                        upd_next   = bad_free ? UPD_NONE : UPD_CLR;
                        state_next = S_DONE;
                    end
                    else if (bad_alloc)
                    begin
                        stat_next  = ST_INVALID;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        scan_ctl.load       = 1'b1;
                        scan_ctl.hole_mode  = strat_reg[1];
                        scan_ctl.want_large = (strat_reg == FIT_WORST);
                        scan_from  = (strat_reg == FIT_NEXT) ? nf_x[IW-1:0] : '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (!scan_stat.running)
                begin
                    if (scan_stat.found)
                    begin
                        lo_next    = SW'(scan_pick);
                        stat_next  = ST_DONE;
                        upd_next   = UPD_SET;
                        nfupd_next = (strat_reg == FIT_NEXT);
                        state_next = S_DONE;
                    end
                    else if ((strat_reg == FIT_NEXT) && !pass2_reg)
                    begin
                        // wrap pass from page 0
                        scan_ctl.load = 1'b1;
                        scan_from     = '0;
                        pass2_next    = 1'b1;
                    end
                    else
                    begin
                        stat_next  = ST_NOFIT;
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    rvalid_next     = 1'b1;
                    rsp_next.status = stat_reg;
                    rsp_next.granted_page = (upd_reg == UPD_SET) ? lo_g[3:0] : 4'd0;
                    if (upd_reg == UPD_SET)
                    begin
                        map_next = map_reg | mask;
                    end
                    else if (upd_reg == UPD_CLR)
                    begin
                        map_next = map_reg & ~mask;
                    end
                    if (nfupd_reg)
                    begin
                        nf_next = nf_sum[4:0];
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            upd_reg    <= UPD_NONE;
            pass2_reg  <= 1'b0;
            nfupd_reg  <= 1'b0;
            strat_reg  <= FIT_FIRST;
            map_reg    <= '0;
            nf_reg     <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            upd_reg    <= upd_next;
            pass2_reg  <= pass2_next;
            nfupd_reg  <= nfupd_next;
            strat_reg  <= strat_next;
            map_reg    <= map_next;
            nf_reg     <= nf_next;
            rvalid_reg <= rvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rsp_reg  <= rsp_next;
        stat_reg <= stat_next;
        cnt_reg  <= cnt_next;
        lo_reg   <= lo_next;
    end

    bpa_scan #(
        .PAGES (PAGES)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (scan_ctl),
        .from  (scan_from),
        .count (cnt_reg),
        .map   (map_reg),
        .stat  (scan_stat),
        .pick  (scan_pick)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rvalid_reg;
    assign rsp       = rsp_reg;

    // Scan unit is quiet whenever a request can be taken
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !scan_stat.running)
        else $error("scan running while idle");

    // Only a successful allocate reports a nonzero page
    a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status != ST_DONE)) |-> (rsp.granted_page == 4'd0))
        else $error("granted page set on failed request");

    // Allocated run must be entirely free before it is claimed
    a_alloc_free: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && slot_free && (upd_reg == UPD_SET))
            |-> ((map_reg & mask) == '0))
        else $error("allocated run overlaps occupied pages");

    // A free leaves its run clear
    a_free_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && slot_free && (upd_reg == UPD_CLR))
            |=> ((map_reg & $past(mask)) == '0))
        else $error("freed run not cleared");

    // One request in flight at a time
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !req_ready)
        else $error("request taken while busy");

endmodule
